@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/pip_pkg.sv @@
package pip_pkg;

  localparam int OFS_W   = 11;
  localparam int CRD_W   = 16;
  localparam int REL_W   = CRD_W + 1;
  localparam int DIF_W   = OFS_W + 1;
  localparam int ARM_W   = REL_W + 1;
  localparam int PROD_W  = ARM_W + DIF_W;

  localparam logic MODE_VERTEX = 1'b0;
  localparam logic MODE_TEST   = 1'b1;

  typedef struct packed {
    logic signed [OFS_W-1:0] x;
    logic signed [OFS_W-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic vld;
    logic prime;
    logic last;
  } edge_ctl_t;

  typedef struct packed {
    logic done;
    logic odd;
  } edge_sts_t;

endpackage

@@ src/pip_vstore.sv @@
module pip_vstore
  import pip_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  vtx_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  input  edge_ctl_t     rd_ctl,
  output vtx_t          rd_data,
  output edge_ctl_t     rd_ctl_q
);

  vtx_t      mem [DEPTH];
  vtx_t      rd_data_r;
  edge_ctl_t rd_ctl_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ctl_r <= '0;
    end else begin
      rd_ctl_r <= rd_ctl;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_ctl_q = rd_ctl_r;

endmodule

@@ src/pip_edge_unit.sv @@
module pip_edge_unit
  import pip_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  edge_ctl_t               ctl,
  input  vtx_t                    cur,
  input  logic signed [REL_W-1:0] dpx,
  input  logic signed [REL_W-1:0] dpy,
  output edge_sts_t               sts
);

  vtx_t                     prev_r;
  logic signed [DIF_W-1:0]  dy;
  logic signed [DIF_W-1:0]  dx;
  logic signed [ARM_W-1:0]  ax;
  logic signed [ARM_W-1:0]  ay;
  logic                     yi_above;
  logic                     yj_above;
  logic signed [PROD_W-1:0] lhs_r, lhs_nxt;
  logic signed [PROD_W-1:0] rhs_r, rhs_nxt;
  logic                     strad_r;
  logic                     dy_pos_r;
  logic                     vld_r;
  logic                     last_r;
  logic                     right;
  logic                     inside_r, inside_nxt;
  logic                     done_r;

  // Edge runs from the previous vertex (j) to the current one (i), relative to centre.
  always_comb begin
    yi_above = $signed({{(REL_W-OFS_W){cur.y[OFS_W-1]}}, cur.y}) > dpy;
    yj_above = $signed({{(REL_W-OFS_W){prev_r.y[OFS_W-1]}}, prev_r.y}) > dpy;
    dy = $signed({prev_r.y[OFS_W-1], prev_r.y}) - $signed({cur.y[OFS_W-1], cur.y});
    dx = $signed({prev_r.x[OFS_W-1], prev_r.x}) - $signed({cur.x[OFS_W-1], cur.x});
    ax = $signed({dpx[REL_W-1], dpx})
       - $signed({{(ARM_W-OFS_W){cur.x[OFS_W-1]}}, cur.x});
    ay = $signed({dpy[REL_W-1], dpy})
       - $signed({{(ARM_W-OFS_W){cur.y[OFS_W-1]}}, cur.y});
    lhs_nxt = ax * dy;
    rhs_nxt = dx * ay;
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prev_r   <= cur;
      lhs_r    <= lhs_nxt;
      rhs_r    <= rhs_nxt;
      strad_r  <= yi_above != yj_above;
      dy_pos_r <= ~dy[DIF_W-1];
      last_r   <= ctl.last;
    end
  end

  // Crossing compare flips with the sign of dy.
  always_comb begin
    right      = dy_pos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r);
    inside_nxt = inside_r;
    if (vld_r && strad_r && right) begin
      inside_nxt = ~inside_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      inside_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      vld_r  <= ctl.vld && !ctl.prime;
      done_r <= vld_r && last_r;
      if (start) begin
        inside_r <= 1'b0;
      end else begin
        inside_r <= inside_nxt;
      end
    end
  end

  assign sts.done = done_r;
  assign sts.odd  = inside_r;

endmodule

@@ src/point_in_polygon_test.sv @@
// Flow: an accepted test primes with the last vertex, then walks the vertices (count clamped
// to MAX_VERTICES; a count of 0 skips the walk) and raises out_valid when the result loads,
// after any stall on the output register. Throughput: one edge per cycle through the shared
// edge unit; no new word is taken before the result loads; vertex writes go back to back.
// Reset: rst_n is synchronous, active low; it clears control and out_valid, not the result bit.
// Vertex store contents are not cleared and must be written before use.
`include "assert_macros.svh"

module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic [3:0]              in_vertex_index,
  input  logic signed [OFS_W-1:0] in_offset_x,
  input  logic signed [OFS_W-1:0] in_offset_y,
  input  logic signed [CRD_W-1:0] in_center_x,
  input  logic signed [CRD_W-1:0] in_center_y,
  input  logic signed [CRD_W-1:0] in_point_x,
  input  logic signed [CRD_W-1:0] in_point_y,
  input  logic [4:0]              in_vertex_total,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_inside_res
);

  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int IW   = (CW > 4) ? CW : 4;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_PUT} state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           rd_idx_r, rd_idx_nxt;
  logic                    first_r, first_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic signed [REL_W-1:0] dpx_r, dpy_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_res_r, out_res_nxt;

  logic                    in_acc;
  logic                    test_acc;
  logic [IW-1:0]           idx_ext;
  logic [CMPW-1:0]         tot_ext;
  logic [CMPW-1:0]         tot_sat;
  logic [CW-1:0]           n_in;
  logic [CW-1:0]           n_in_m1;
  logic                    wr_en;
  logic                    slot_free;
  logic                    last_rd;
  vtx_t                    wr_data;
  vtx_t                    rd_data;
  edge_ctl_t               rd_ctl;
  edge_ctl_t               rd_ctl_q;
  edge_sts_t               sts;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign test_acc  = in_acc && (in_mode == MODE_TEST);
  assign slot_free = !out_valid_r || out_ready;

  assign idx_ext = IW'(in_vertex_index);
  assign wr_en   = in_acc && (in_mode == MODE_VERTEX) && (idx_ext < IW'(MAX_VERTICES));
  assign wr_data = '{x: in_offset_x, y: in_offset_y};

  // Clamp the vertex count to the store depth.
  assign tot_ext = CMPW'(in_vertex_total);
  assign tot_sat = (tot_ext > CMPW'(MAX_VERTICES)) ? CMPW'(MAX_VERTICES) : tot_ext;
  assign n_in    = tot_sat[CW-1:0];
  assign n_in_m1 = n_in - CW'(1);

  assign last_rd = !first_r && ((CW'(rd_idx_r) + CW'(1)) == n_r);

  always_comb begin
    rd_ctl.vld   = (state_r == S_RUN);
    rd_ctl.prime = first_r;
    rd_ctl.last  = last_rd;
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    first_nxt     = first_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    unique case (state_r)
      S_IDLE: begin
        if (test_acc) begin
          n_nxt      = n_in;
          rd_idx_nxt = n_in_m1[AW-1:0];
          first_nxt  = 1'b1;
          state_nxt  = (n_in == '0) ? S_PUT : S_RUN;
        end
      end
      S_RUN: begin
        // Prime with the last vertex, then walk 0 .. n-1.
        if (first_r) begin
          first_nxt  = 1'b0;
          rd_idx_nxt = '0;
        end else if (last_rd) begin
          state_nxt = S_WAIT;
        end else begin
          rd_idx_nxt = rd_idx_r + AW'(1);
        end
      end
      S_WAIT: begin
        if (sts.done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = sts.odd;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    n_r       <= n_nxt;
    out_res_r <= out_res_nxt;
    if (test_acc) begin
      dpx_r <= $signed({in_point_x[CRD_W-1], in_point_x})
             - $signed({in_center_x[CRD_W-1], in_center_x});
      dpy_r <= $signed({in_point_y[CRD_W-1], in_point_y})
             - $signed({in_center_y[CRD_W-1], in_center_y});
    end
  end

  pip_vstore #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_vstore (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (idx_ext[AW-1:0]),
    .wr_data  (wr_data),
    .rd_addr  (rd_idx_r),
    .rd_ctl   (rd_ctl),
    .rd_data  (rd_data),
    .rd_ctl_q (rd_ctl_q)
  );

  pip_edge_unit u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (test_acc),
    .ctl   (rd_ctl_q),
    .cur   (rd_data),
    .dpx   (dpx_r),
    .dpy   (dpy_r),
    .sts   (sts)
  );

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r;

  `ASSERT_CLK(a_done_in_wait, sts.done |-> state_r == S_WAIT, "edge walk finished outside wait")
  `ASSERT_CLK(a_empty_poly, test_acc && in_vertex_total == 5'd0 |=> state_r == S_PUT, "empty polygon did not skip walk")
  `ASSERT_CLK(a_put_loads, state_r == S_PUT && slot_free |=> out_valid_r && state_r == S_IDLE, "result word not loaded")
  `ASSERT_CLK(a_no_edge_idle, state_r == S_IDLE |-> !rd_ctl.vld, "edge issued while idle")

endmodule
